// File: design/dcache_request_port_arbiter_assert.svh
// assertion macros for the request port arbiter
`ifndef DCACHE_REQUEST_PORT_ARBITER_ASSERT_SVH
`define DCACHE_REQUEST_PORT_ARBITER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DRPA_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define DRPA_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define DRPA_ASSERT_IMP(label, clk, rst_n, a, c)
`define DRPA_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// File: design/drpa_pkg.sv
package drpa_pkg;
  localparam int QUEUE_DEPTH_DEF  = 64;
  localparam int LOCK_ENTRIES_DEF = 8;
  localparam int MAX_PORTS_DEF    = 4;
  localparam int ADDR_BITS_DEF    = 48;

  localparam logic [1:0] KIND_REQ    = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_RETRY  = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_RMW_WRITE = 3'd1;
  localparam logic [2:0] ERR_RETRY     = 3'd2;
  localparam logic [2:0] ERR_FULL      = 3'd3;
  localparam logic [2:0] ERR_DBL_LOCK  = 3'd4;
  localparam logic [2:0] ERR_LOCK_FULL = 3'd5;

  localparam logic CFG_NUM_PORTS   = 1'b0;
  localparam logic CFG_LINE_OFFSET = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] request_addr;
    logic [15:0] request_tag;
    logic        is_core;
    logic        is_locked_rmw;
    logic        is_write;
    logic [2:0]  accept_budget;
  } in_word_t;

  typedef struct packed {
    logic        issued;
    logic [15:0] issued_tag;
    logic [47:0] issued_addr;
    logic [2:0]  error_code;
    logic        port_blocked;
    logic [6:0]  queue_count;
    logic        last;
  } out_word_t;

  // lock search request / reply
  typedef struct packed {
    logic start;
  } lk_req_t;

  typedef struct packed {
    logic busy;
    logic hit;
    logic free_found;
  } lk_stat_t;
endpackage

// File: design/dcache_request_port_arbiter.sv
// Request port arbiter in front of a data cache.
// Input channel in_valid/in_ready/in_data carries one word per event: a new
// request, a cycle tick or a downstream retry. Each event produces one or
// more result words on out_valid/out_ready/out_data: one per issued request,
// then a final word with last set and the first error of the event.
// Config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes num_ports and
// line_offset_bits; write only while idle.
// Core requests drain before stream requests, each class in FIFO order;
// queues live in registered-read RAMs.
// Timing: each lock check scans the lock table one entry a cycle. A new
// request first gets an admission check against the lock table; each head
// then passes the drain test, the registered RAM read, the head latch, a
// lock scan and the issue step up to its result word (a head stalled on a
// locked line ends the drain instead), and the final word is registered
// before it is shown. in_ready is low while an event runs and returns the
// cycle after the final word is taken.
// A stalled receiver holds the sequencer at the result word until taken.
// Reset (synchronous, active low) empties both queues, clears the lock table,
// the blocked flag, the pending drain and ports used; config returns to
// num_ports 1, line_offset_bits 6.
module dcache_request_port_arbiter #(
  parameter int QUEUE_DEPTH  = drpa_pkg::QUEUE_DEPTH_DEF,
  parameter int LOCK_ENTRIES = drpa_pkg::LOCK_ENTRIES_DEF,
  parameter int MAX_PORTS    = drpa_pkg::MAX_PORTS_DEF,
  parameter int ADDR_BITS    = drpa_pkg::ADDR_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  drpa_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output drpa_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [3:0]          cfg_data
);
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = $clog2(MAX_PORTS + 1);
  localparam int IW = 18;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_ENQ   = 8'b00000010,
    ST_RD    = 8'b00000100,
    ST_HEAD  = 8'b00001000,
    ST_SCAN  = 8'b00010000,
    ST_ISSUE = 8'b00100000,
    ST_OUT   = 8'b01000000,
    ST_FIN   = 8'b10000000
  } st_t;

  st_t st_r;
  drpa_pkg::in_word_t in_r;
  logic [2:0]  num_ports_r;
  logic [3:0]  loff_r;
  logic [CW-1:0] ccnt_r, ocnt_r;
  logic [QW-1:0] chead_r, ohead_r;
  logic blocked_r, pend_r;
  logic [PW-1:0] used_r;
  logic [2:0] budget_r, err_r;
  logic from_core_r, enq_chk_r, after_drain_r;
  drpa_pkg::out_word_t res_r;

  // effective ports
  logic [PW-1:0] eff_ports;
  always_comb begin
    if (num_ports_r == 3'd0) eff_ports = PW'(1);
    else if (32'(num_ports_r) > MAX_PORTS) eff_ports = PW'(MAX_PORTS);
    else eff_ports = PW'(num_ports_r);
  end

  // line address masking
  function automatic logic [ADDR_BITS-1:0] line_of(input logic [ADDR_BITS-1:0] a,
                                                   input logic [3:0] ob);
    logic [ADDR_BITS-1:0] m;
    m = ~((ADDR_BITS'(1) << ob) - ADDR_BITS'(1));
    return a & m;
  endfunction

  // queue memories
  logic [QW-1:0] c_tail, o_tail;
  logic c_we, o_we;
  logic [ADDR_BITS-1:0] c_addr_q, o_addr_q, req_addr;
  logic [IW-1:0] c_info_q, o_info_q, req_info;
  logic [CW-1:0] ct_sum, ot_sum;
  assign ct_sum = CW'(chead_r) + ccnt_r;
  assign ot_sum = CW'(ohead_r) + ocnt_r;
  assign c_tail = (ct_sum >= CW'(QUEUE_DEPTH)) ? QW'(ct_sum - CW'(QUEUE_DEPTH))
                                               : QW'(ct_sum);
  assign o_tail = (ot_sum >= CW'(QUEUE_DEPTH)) ? QW'(ot_sum - CW'(QUEUE_DEPTH))
                                               : QW'(ot_sum);
  assign req_addr = ADDR_BITS'(in_r.request_addr);
  assign req_info = {in_r.is_write, in_r.is_locked_rmw, in_r.request_tag};

  drpa_ram #(.WIDTH(ADDR_BITS), .DEPTH(QUEUE_DEPTH)) u_caddr (
    .clk, .we(c_we), .waddr(c_tail), .wdata(req_addr), .raddr(chead_r), .rdata(c_addr_q));
  drpa_ram #(.WIDTH(IW), .DEPTH(QUEUE_DEPTH)) u_cinfo (
    .clk, .we(c_we), .waddr(c_tail), .wdata(req_info), .raddr(chead_r), .rdata(c_info_q));
  drpa_ram #(.WIDTH(ADDR_BITS), .DEPTH(QUEUE_DEPTH)) u_oaddr (
    .clk, .we(o_we), .waddr(o_tail), .wdata(req_addr), .raddr(ohead_r), .rdata(o_addr_q));
  drpa_ram #(.WIDTH(IW), .DEPTH(QUEUE_DEPTH)) u_oinfo (
    .clk, .we(o_we), .waddr(o_tail), .wdata(req_info), .raddr(ohead_r), .rdata(o_info_q));

  // head latch
  logic [ADDR_BITS-1:0] h_addr_r;
  logic [IW-1:0] h_info_r;
  logic h_rmw, h_wr;
  assign h_rmw = h_info_r[16];
  assign h_wr  = h_info_r[17];

  // lock table
  drpa_pkg::lk_req_t lk_req;
  drpa_pkg::lk_stat_t lk_stat;
  logic [ADDR_BITS-1:0] lk_line;
  logic do_lock, do_unlock;
  drpa_lock_table #(.LOCK_ENTRIES(LOCK_ENTRIES), .LINE_BITS(ADDR_BITS)) u_lock (
    .clk, .rst_n, .req(lk_req), .line(lk_line), .do_lock, .do_unlock, .stat(lk_stat));
  assign lk_line = line_of(enq_chk_r ? req_addr : h_addr_r, loff_r);

  logic [CW:0] total;
  assign total = (CW+1)'(ccnt_r) + (CW+1)'(ocnt_r);
  logic drain_go;
  assign drain_go = (total != '0) && !blocked_r && (used_r < eff_ports);

  logic fin_shown;
  assign fin_shown = (st_r == ST_FIN) && after_drain_r;

  assign in_ready  = (st_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (st_r == ST_OUT) || fin_shown;
  assign out_data  = res_r;

  logic lk_busy;
  assign lk_busy = lk_stat.busy;

  // lock action code of the head being issued
  logic [2:0] iss_err;
  always_comb begin
    iss_err = drpa_pkg::ERR_OK;
    if (h_rmw) begin
      if (!h_wr) begin
        if (lk_stat.hit) iss_err = drpa_pkg::ERR_DBL_LOCK;
        else if (!lk_stat.free_found) iss_err = drpa_pkg::ERR_LOCK_FULL;
      end else if (!lk_stat.hit) iss_err = drpa_pkg::ERR_RMW_WRITE;
    end
  end

  always_comb begin
    lk_req.start = 1'b0;
    c_we = 1'b0;
    o_we = 1'b0;
    do_lock = 1'b0;
    do_unlock = 1'b0;
    if (st_r == ST_IDLE && in_valid && in_data.kind == drpa_pkg::KIND_REQ)
      lk_req.start = 1'b1;
    if (st_r == ST_HEAD) lk_req.start = 1'b1;
    if (st_r == ST_ENQ && !lk_busy && total < (CW+1)'(QUEUE_DEPTH) &&
        !(in_r.is_locked_rmw && in_r.is_write && (!in_r.is_core || !lk_stat.hit))) begin
      c_we = in_r.is_core;
      o_we = !in_r.is_core;
    end
    if (st_r == ST_ISSUE && h_rmw && budget_r != 3'd0) begin
      if (!h_wr && !lk_stat.hit && lk_stat.free_found) do_lock = 1'b1;
      if (h_wr && lk_stat.hit) do_unlock = 1'b1;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      num_ports_r <= 3'd1;
      loff_r      <= 4'd6;
      ccnt_r      <= '0;
      ocnt_r      <= '0;
      chead_r     <= '0;
      ohead_r     <= '0;
      blocked_r   <= 1'b0;
      pend_r      <= 1'b0;
      used_r      <= '0;
      enq_chk_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == drpa_pkg::CFG_NUM_PORTS) num_ports_r <= cfg_data[2:0];
        else loff_r <= cfg_data;
      end
      unique case (st_r)
        ST_IDLE: begin
          if (in_valid) begin
            in_r     <= in_data;
            budget_r <= in_data.accept_budget;
            err_r    <= drpa_pkg::ERR_OK;
            after_drain_r <= 1'b0;
            if (in_data.kind == drpa_pkg::KIND_REQ) begin
              enq_chk_r <= 1'b1;
              st_r      <= ST_ENQ;
            end else if (in_data.kind == drpa_pkg::KIND_TICK) begin
              used_r <= '0;
              if (pend_r && !blocked_r) begin
                pend_r <= 1'b0;
                st_r   <= ST_RD;
              end else st_r <= ST_FIN;
            end else if (in_data.kind == drpa_pkg::KIND_RETRY) begin
              if (!blocked_r) begin
                err_r <= drpa_pkg::ERR_RETRY;
                st_r  <= ST_FIN;
              end else begin
                blocked_r <= 1'b0;
                pend_r    <= 1'b0;
                st_r      <= ST_RD;
              end
            end else st_r <= ST_FIN;
          end
        end
        ST_ENQ: begin
          if (!lk_busy) begin
            enq_chk_r <= 1'b0;
            if (total >= (CW+1)'(QUEUE_DEPTH)) begin
              err_r <= drpa_pkg::ERR_FULL;
              st_r  <= ST_FIN;
            end else if (in_r.is_locked_rmw && in_r.is_write &&
                         (!in_r.is_core || !lk_stat.hit)) begin
              err_r <= drpa_pkg::ERR_RMW_WRITE;
              st_r  <= ST_FIN;
            end else begin
              if (in_r.is_core) ccnt_r <= ccnt_r + 1'b1;
              else ocnt_r <= ocnt_r + 1'b1;
              if (blocked_r) st_r <= ST_FIN;
              else if (used_r >= eff_ports) begin
                pend_r <= 1'b1;
                st_r   <= ST_FIN;
              end else begin
                pend_r <= 1'b0;
                st_r   <= ST_RD;
              end
            end
          end
        end
        ST_RD: begin
          // loop test of the drain; RAM read issued on head pointers
          if (drain_go) begin
            from_core_r <= (ccnt_r != '0);
            st_r <= ST_HEAD;
          end else begin
            if (!blocked_r && total != '0) pend_r <= 1'b1;
            st_r <= ST_FIN;
          end
        end
        ST_HEAD: begin
          h_addr_r <= from_core_r ? c_addr_q : o_addr_q;
          h_info_r <= from_core_r ? c_info_q : o_info_q;
          st_r <= ST_SCAN;
        end
        ST_SCAN: begin
          if (!lk_busy) st_r <= ST_ISSUE;
        end
        ST_ISSUE: begin
          if (lk_stat.hit && !(h_rmw && h_wr)) begin
            st_r <= ST_FIN;
          end else if (budget_r == 3'd0) begin
            blocked_r <= 1'b1;
            pend_r    <= 1'b0;
            st_r      <= ST_FIN;
          end else begin
            budget_r <= budget_r - 1'b1;
            used_r   <= used_r + 1'b1;
            if (from_core_r) begin
              chead_r <= (chead_r == QW'(QUEUE_DEPTH - 1)) ? '0 : chead_r + 1'b1;
              ccnt_r  <= ccnt_r - 1'b1;
            end else begin
              ohead_r <= (ohead_r == QW'(QUEUE_DEPTH - 1)) ? '0 : ohead_r + 1'b1;
              ocnt_r  <= ocnt_r - 1'b1;
            end
            if (err_r == drpa_pkg::ERR_OK) err_r <= iss_err;
            res_r <= '{issued: 1'b1, issued_tag: h_info_r[15:0],
                       issued_addr: 48'(h_addr_r), error_code: iss_err,
                       port_blocked: blocked_r, queue_count: 7'(total - 1'b1),
                       last: 1'b0};
            st_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_ready) st_r <= ST_RD;
        end
        ST_FIN: begin
          if (!after_drain_r) begin
            after_drain_r <= 1'b1;
            res_r <= '{issued: 1'b0, issued_tag: '0, issued_addr: '0,
                       error_code: err_r, port_blocked: blocked_r,
                       queue_count: 7'(total), last: 1'b1};
          end else if (out_ready) st_r <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

`include "dcache_request_port_arbiter_assert.svh"
  `DRPA_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, total <= (CW+1)'(QUEUE_DEPTH))
  `DRPA_ASSERT_IMP(a_busy_not_ready, clk, rst_n, out_valid, !in_ready)
  `DRPA_ASSERT_NXT(a_out_hold, clk, rst_n, st_r == ST_OUT && !out_ready, st_r == ST_OUT)
  `DRPA_ASSERT_NXT(a_fin_hold, clk, rst_n, fin_shown && !out_ready, fin_shown)
endmodule

// File: design/drpa_ram.sv
module drpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: design/drpa_lock_table.sv
module drpa_lock_table #(
  parameter int LOCK_ENTRIES = 8,
  parameter int LINE_BITS    = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  drpa_pkg::lk_req_t    req,
  input  logic [LINE_BITS-1:0] line,
  input  logic                 do_lock,
  input  logic                 do_unlock,
  output drpa_pkg::lk_stat_t   stat
);
  localparam int IW = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;
  localparam int CW = $clog2(LOCK_ENTRIES + 1);

  logic [LINE_BITS-1:0] line_r [LOCK_ENTRIES];
  logic [LOCK_ENTRIES-1:0] valid_r;
  logic [CW-1:0] idx_r;
  logic          busy_r, hit_r, free_r;
  logic [IW-1:0] hit_idx_r, free_idx_r;
  logic [IW-1:0] idx;
  logic          match;

  assign idx   = idx_r[IW-1:0];
  assign match = valid_r[idx] && (line_r[idx] == line);
  assign stat  = '{busy: busy_r || req.start, hit: hit_r, free_found: free_r};

  // sequential scan over the table, one entry a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      busy_r  <= 1'b0;
      idx_r   <= '0;
      hit_r   <= 1'b0;
      free_r  <= 1'b0;
    end else begin
      if (req.start) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end else if (busy_r) begin
        if (match && !hit_r) begin
          hit_r     <= 1'b1;
          hit_idx_r <= idx;
        end
        if (!valid_r[idx] && !free_r) begin
          free_r     <= 1'b1;
          free_idx_r <= idx;
        end
        if (idx_r == CW'(LOCK_ENTRIES - 1)) busy_r <= 1'b0;
        idx_r <= idx_r + 1'b1;
      end
      if (do_lock) begin
        valid_r[free_idx_r] <= 1'b1;
        line_r[free_idx_r]  <= line;
      end
      if (do_unlock) valid_r[hit_idx_r] <= 1'b0;
    end
  end

`include "dcache_request_port_arbiter_assert.svh"
  `DRPA_ASSERT_IMP(a_lock_needs_free, clk, rst_n, do_lock, free_r && !hit_r)
  `DRPA_ASSERT_IMP(a_unlock_needs_hit, clk, rst_n, do_unlock, hit_r)
  `DRPA_ASSERT_IMP(a_no_op_while_busy, clk, rst_n, busy_r, !do_lock && !do_unlock)
endmodule
